@@ rtl/core/mtss_pkg.sv @@
// Package for the multi-tone sine synthesizer: default parameters, register
// map, reset values, the ROM entry type and the quarter-wave sine generator.
// No dependencies.
package mtss_pkg;

  localparam int unsigned TONE_COUNT_DEF    = 3;
  localparam int unsigned PHASE_WIDTH_DEF   = 32;
  localparam int unsigned SINE_ADDR_BITS_DEF = 10;

  localparam int unsigned REG_TONES  = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned GAIN_W     = 15;
  localparam int unsigned MAG_W      = 15;
  localparam int unsigned SAMPLE_W   = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_INC_BASE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_BASE = 3'd3;

  localparam logic [REG_TONES-1:0][31:0] INC_RESET =
    {32'd157482134, 32'd78741067, 32'd39370534};
  localparam logic [REG_TONES-1:0][GAIN_W-1:0] GAIN_RESET =
    {15'd3277, 15'd6554, 15'd9830};

  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [63:0] HALF_Q30 = 64'd1 << 29;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
  } sine_t;

  // 32767*sin(x), x in Q30 on [0, pi/2], Taylor series to the x^21 term
  function automatic logic [MAG_W-1:0] sine_q15(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd210;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd272;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd342;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd420;
    sum  = sum + term;
    if (sum > ONE_Q30) begin
      sum = ONE_Q30;
    end
    return MAG_W'((sum * 64'd32767 + HALF_Q30) >> 30);
  endfunction

  // entry i of the quarter-wave table, sampled at mid-step
  function automatic logic [MAG_W-1:0] quarter_entry(int unsigned i, int unsigned abits);
    logic [63:0] x;
    x = (PI_Q30 * (64'(2 * i) + 64'd1)) >> (abits + 2);
    return sine_q15(x);
  endfunction

endpackage

@@ rtl/core/multi_tone_sine_synthesizer.sv @@
// Multi-tone DDS sine synthesizer top level: phase accumulators, per-tone
// sine ROMs, gain multipliers and the saturating mixer.
// Depends on mtss_pkg and mtss_sine_rom.
//
//  channel   | direction | handshake                   | payload
//  ----------+-----------+-----------------------------+-------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready | tdata[0] sample_tick
//  m_axis    | out       | m_axis_tvalid/m_axis_tready | tdata[15:0] mixed_sample
//  cfg       | in        | cfg_we_i                    | cfg_index_i, cfg_data_i
//
// One transaction per clock while the output is not stalled; a tick's sample passes
// the registered stages ROM read, gain multiply and mix/round/saturate in order.
// A transaction with sample_tick low is taken and produces nothing.
// Stages move independently; input is taken while a result waits if a stage is free.
// Async active-low reset clears phases and valids and loads register defaults.
module multi_tone_sine_synthesizer #(
  parameter int unsigned TONE_COUNT           = mtss_pkg::TONE_COUNT_DEF,
  parameter int unsigned PHASE_WIDTH          = mtss_pkg::PHASE_WIDTH_DEF,
  parameter int unsigned SINE_TABLE_ADDR_BITS = mtss_pkg::SINE_ADDR_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // [0] sample_tick
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [mtss_pkg::SAMPLE_W-1:0]       m_axis_tdata,  // [15:0] mixed_sample
  input  logic                                cfg_we_i,
  input  logic [mtss_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mtss_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned ProdW = 32;
  localparam int unsigned SumW  = ProdW + $clog2(TONE_COUNT + 1) + 1;

  logic [TONE_COUNT-1:0][PHASE_WIDTH-1:0]           phase_q;
  logic [TONE_COUNT-1:0][PHASE_WIDTH-1:0]           inc_q;
  logic [TONE_COUNT-1:0][mtss_pkg::GAIN_W-1:0]      gain_q;
  mtss_pkg::sine_t [TONE_COUNT-1:0]                 sine;
  logic signed [ProdW-1:0]                          gain_x [TONE_COUNT];
  logic signed [ProdW-1:0]                          sine_x [TONE_COUNT];
  logic [TONE_COUNT-1:0][ProdW-1:0]                 prod_q;
  logic [mtss_pkg::SAMPLE_W-1:0]                    out_q;
  logic [mtss_pkg::SAMPLE_W-1:0]                    out_d;
  logic                                             v1_q, v2_q, v3_q;
  logic                                             en1, en2, en3;
  logic                                             tick_acc;
  logic signed [SumW-1:0]                           acc;
  logic signed [SumW-1:0]                           rnd;

  assign en3 = !v3_q || m_axis_tready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign s_axis_tready = en1;
  assign tick_acc      = s_axis_tvalid && en1 && s_axis_tdata[0];

  // config registers and phase accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TONE_COUNT; k++) begin
        phase_q[k] <= '0;
        if (k < mtss_pkg::REG_TONES) begin
          inc_q[k]  <= PHASE_WIDTH'(mtss_pkg::INC_RESET[k]);
          gain_q[k] <= mtss_pkg::GAIN_RESET[k];
        end else begin
          inc_q[k]  <= '0;
          gain_q[k] <= '0;
        end
      end
    end else begin
      for (int k = 0; k < TONE_COUNT; k++) begin
        if (tick_acc) begin
          phase_q[k] <= phase_q[k] + inc_q[k];
        end
        if (k < mtss_pkg::REG_TONES && cfg_we_i) begin
          if (cfg_index_i == mtss_pkg::CFG_INC_BASE + mtss_pkg::CFG_IDX_W'(k)) begin
            inc_q[k] <= PHASE_WIDTH'(cfg_data_i);
          end
          if (cfg_index_i == mtss_pkg::CFG_GAIN_BASE + mtss_pkg::CFG_IDX_W'(k)) begin
            gain_q[k] <= cfg_data_i[mtss_pkg::GAIN_W-1:0];
          end
        end
      end
    end
  end

  for (genvar k = 0; k < TONE_COUNT; k++) begin : g_tone
    mtss_sine_rom #(
      .PHASE_WIDTH (PHASE_WIDTH),
      .ADDR_BITS   (SINE_TABLE_ADDR_BITS)
    ) u_rom (
      .clk_i   (clk_i),
      .en_i    (en1),
      .phase_i (phase_q[k]),
      .sine_o  (sine[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= tick_acc;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  // signed operands at product width
  always_comb begin
    for (int k = 0; k < TONE_COUNT; k++) begin
      gain_x[k] = $signed(ProdW'(gain_q[k]));
      sine_x[k] = sine[k].neg ? -$signed(ProdW'(sine[k].mag))
                              :  $signed(ProdW'(sine[k].mag));
    end
  end

  // gain multiply
  always_ff @(posedge clk_i) begin
    if (en2) begin
      for (int k = 0; k < TONE_COUNT; k++) begin
        prod_q[k] <= gain_x[k] * sine_x[k];
      end
    end
  end

  // mix, round half up to Q15, saturate
  always_comb begin
    acc = '0;
    for (int k = 0; k < TONE_COUNT; k++) begin
      acc = acc + SumW'($signed(prod_q[k]));
    end
    rnd = (acc + SumW'(1 << 14)) >>> 15;
    priority if (rnd > SumW'(32767)) begin
      out_d = 16'h7fff;
    end else if (rnd < -SumW'(32768)) begin
      out_d = 16'h8000;
    end else begin
      out_d = rnd[mtss_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = out_q;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tick_acc |=> $stable(phase_q[0]))
    else $error("phase moved without a tick");

  a_stage1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !en2) |=> v1_q)
    else $error("stage 1 sample dropped under stall");

endmodule

@@ rtl/core/mtss_sine_rom.sv @@
// Quarter-wave sine ROM with quadrant decode and registered read.
// Depends on mtss_pkg (sine_t, quarter_entry).
module mtss_sine_rom #(
  parameter int unsigned PHASE_WIDTH = mtss_pkg::PHASE_WIDTH_DEF,
  parameter int unsigned ADDR_BITS   = mtss_pkg::SINE_ADDR_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [PHASE_WIDTH-1:0] phase_i,
  output mtss_pkg::sine_t        sine_o
);

  localparam int unsigned Depth = 1 << ADDR_BITS;

  typedef logic [Depth-1:0][mtss_pkg::MAG_W-1:0] rom_t;

  function automatic rom_t build_rom();
    rom_t r;
    for (int unsigned i = 0; i < Depth; i++) begin
      r[i] = mtss_pkg::quarter_entry(i, ADDR_BITS);
    end
    return r;
  endfunction

  localparam rom_t RomData = build_rom();

  logic [ADDR_BITS+1:0] addr;
  logic [1:0]           quad;
  logic [ADDR_BITS-1:0] idx;
  mtss_pkg::sine_t      sine_q;

  assign addr = phase_i[PHASE_WIDTH-1 -: ADDR_BITS+2];
  assign quad = addr[ADDR_BITS+1:ADDR_BITS];
  assign idx  = quad[0] ? ~addr[ADDR_BITS-1:0] : addr[ADDR_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sine_q.mag <= RomData[idx];
      sine_q.neg <= quad[1];
    end
  end

  assign sine_o = sine_q;

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for multi_tone_sine_synthesizer: streams sample ticks,
// predicts each mixed sample from its own phase/gain model and sine table.
// Depends on mtss_pkg and the synthesizer RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int TONES         = 3;
  localparam int TABLE_BITS    = 10;
  localparam int TABLE_SIZE    = 1 << TABLE_BITS;
  localparam int IDLE_PCT      = 9;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  localparam logic [mtss_pkg::CFG_IDX_W-1:0] REG_INC0   = mtss_pkg::CFG_INC_BASE;
  localparam logic [mtss_pkg::CFG_IDX_W-1:0] REG_GAIN0  = mtss_pkg::CFG_GAIN_BASE;
  localparam logic [mtss_pkg::CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
  localparam logic [mtss_pkg::CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata  = '0;  // [0] sample_tick
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [mtss_pkg::SAMPLE_W-1:0]   m_axis_tdata;        // [15:0] mixed_sample
  logic                            cfg_we_i      = 1'b0;
  logic [mtss_pkg::CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [mtss_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;

  multi_tone_sine_synthesizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  logic [14:0] quarter_tab [TABLE_SIZE];
  logic [31:0] tone_phase [TONES];
  logic [31:0] tone_inc [TONES];
  logic [14:0] tone_gain [TONES];

  logic                          tick_queue [$];
  logic [mtss_pkg::SAMPLE_W-1:0] expected_mix [$];
  logic              steady       = 1'b0;
  int                fail_count   = 0;
  int                inputs_taken = 0;
  int                blank_inputs = 0;
  int                samples_checked = 0;
  int                settings_used = 0;
  int                stall_cycles = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin : build_quarter_table
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    int i;
    int n;
    for (i = 0; i < TABLE_SIZE; i++) begin
      x    = (PI_Q30 * (2 * longint'(i) + 1)) >> (TABLE_BITS + 2);
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (n = 1; n <= 10; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = (sum >= term) ? sum - term : 0;
        end else begin
          sum = sum + term;
        end
      end
      if (sum > (64'd1 << 30)) begin
        sum = 64'd1 << 30;
      end
      quarter_tab[i] = 15'((sum * 32767 + (64'd1 << 29)) >> 30);
    end
  end

  // weighted sum of the tone sines, then every phase steps forward
  function automatic logic [mtss_pkg::SAMPLE_W-1:0] next_mix();
    longint acc;
    longint s;
    logic [11:0] addr;
    logic [9:0] idx;
    int k;
    acc = 0;
    for (k = 0; k < TONES; k++) begin
      addr = tone_phase[k][31:20];
      idx  = addr[10] ? ~addr[9:0] : addr[9:0];
      s    = quarter_tab[idx];
      if (addr[11]) begin
        s = -s;
      end
      acc = acc + longint'(tone_gain[k]) * s;
      tone_phase[k] = tone_phase[k] + tone_inc[k];
    end
    acc = (acc + 16384) >>> 15;
    if (acc > 32767) begin
      acc = 32767;
    end else if (acc < -32768) begin
      acc = -32768;
    end
    return acc[mtss_pkg::SAMPLE_W-1:0];
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  // driver: one tick per transaction from the pending queue
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        inputs_taken++;
        if (s_axis_tdata[0]) begin
          expected_mix.push_back(next_mix());
        end else begin
          blank_inputs++;
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tick_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'd0, tick_queue.pop_front()};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each output transaction with the oldest prediction
  always @(posedge clk_i) begin : monitor
    logic [mtss_pkg::SAMPLE_W-1:0] want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_mix.size() == 0) begin
          note_failure($sformatf("unexpected sample %0d with nothing pending",
                                 $signed(m_axis_tdata)));
        end else begin
          want = expected_mix.pop_front();
          samples_checked++;
          if (m_axis_tdata !== want) begin
            note_failure($sformatf("mixed_sample mismatch: expected %0d got %0d",
                                   $signed(want), $signed(m_axis_tdata)));
          end
        end
      end
      m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          cfg_we_i) begin
        stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
        $display("No transaction for %0d cycles, %0d samples outstanding",
                 STALL_LIMIT, expected_mix.size());
        $display("Regression FAIL");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic drain();
    do @(negedge clk_i);
    while (tick_queue.size() != 0 || s_axis_tvalid || expected_mix.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [mtss_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mtss_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx < mtss_pkg::CFG_GAIN_BASE) begin
      tone_inc[idx - mtss_pkg::CFG_INC_BASE] = data;
    end else if (idx < mtss_pkg::CFG_GAIN_BASE + mtss_pkg::REG_TONES) begin
      tone_gain[idx - mtss_pkg::CFG_GAIN_BASE] = data[14:0];
    end
  endtask

  task automatic load_tones(input logic [31:0] i0, input logic [31:0] i1, input logic [31:0] i2,
                            input logic [31:0] g0, input logic [31:0] g1, input logic [31:0] g2);
    write_reg(REG_INC0,        i0);
    write_reg(REG_INC0 + 3'd1, i1);
    write_reg(REG_INC0 + 3'd2, i2);
    write_reg(REG_GAIN0,        g0);
    write_reg(REG_GAIN0 + 3'd1, g1);
    write_reg(REG_GAIN0 + 3'd2, g2);
    settings_used++;
  endtask

  task automatic run_phase(input int count, input int tick_pct);
    repeat (count) tick_queue.push_back($urandom_range(99) < tick_pct);
    drain();
  endtask

  function automatic logic [31:0] rand_inc();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(32'h0010_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(4))
      0:       return '0;
      1:       return 32'h7FFF;
      2:       return $urandom();
      default: return $urandom_range(32'h7FFF);
    endcase
  endfunction

  initial begin : stimulus
    logic opening [16] = '{0, 1, 1, 1, 1, 0, 0, 1, 1, 1, 1, 1, 0, 1, 1, 1};
    int k;
    int p;
    for (k = 0; k < TONES; k++) begin
      tone_phase[k] = '0;
      tone_inc[k]   = mtss_pkg::INC_RESET[k];
      tone_gain[k]  = mtss_pkg::GAIN_RESET[k];
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset tuning, blank and real ticks
    foreach (opening[j]) tick_queue.push_back(opening[j]);
    drain();

    // spare indexes must be ignored; align all tones to a quarter turn at full gain
    write_reg(REG_SPARE6, '1);
    write_reg(REG_SPARE7, '1);
    for (k = 0; k < TONES; k++) begin
      write_reg(REG_INC0 + mtss_pkg::CFG_IDX_W'(k), 32'h4000_0000 - tone_phase[k]);
      write_reg(REG_GAIN0 + mtss_pkg::CFG_IDX_W'(k), '1);
    end
    settings_used++;
    tick_queue.push_back(1'b1);
    drain();

    // half-turn steps swing between positive and negative saturation
    for (k = 0; k < TONES; k++) begin
      write_reg(REG_INC0 + mtss_pkg::CFG_IDX_W'(k), 32'h8000_0000);
    end
    settings_used++;
    tick_queue.push_back(1'b1);
    tick_queue.push_back(1'b1);
    tick_queue.push_back(1'b0);
    tick_queue.push_back(1'b1);
    tick_queue.push_back(1'b1);
    drain();

    load_tones('1, '1, '1, 32'h7FFF, 32'h7FFF, 32'h7FFF);
    run_phase(150, 80);
    load_tones('0, '0, '0, '0, '0, '0);
    run_phase(60, 70);
    for (p = 0; p < 8; p++) begin
      steady = (p == 3);
      load_tones(rand_inc(), rand_inc(), rand_inc(), rand_gain(), rand_gain(), rand_gain());
      run_phase(140, 85);
    end
    steady = 1'b0;

    $display("Took %0d input transactions (%0d blank), checked %0d mixed samples",
             inputs_taken, blank_inputs, samples_checked);
    $display("Register settings exercised: %0d, failures: %0d", settings_used, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
